// ===== hdl/quaternion_to_swing_twist_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the quaternion swing/twist converter.
// Shared property shapes with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_SWING_TWIST_ASSERT_SVH
`define QUATERNION_TO_SWING_TWIST_ASSERT_SVH

// Antecedent in this cycle implies consequent in the same cycle.
`define QST_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define QST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/qst_pkg.sv =====
// ----------------------------------------------------------------------------
// qst_pkg
// Types, constants and CORDIC step functions for the swing/twist converter.
// ----------------------------------------------------------------------------
`default_nettype none

package qst_pkg;

  // Number of CORDIC iterations per unit.
  localparam int unsigned CORDIC_STEPS = 20;
  // Datapath width for CORDIC vectors.
  localparam int unsigned DW = 40;
  // Angle width, units of 2^-16 degree.
  localparam int unsigned AW = 32;

  typedef logic signed [DW-1:0] dat_t;
  typedef logic signed [AW-1:0] ang_t;

  localparam ang_t ANG_FULL    = 32'sd23592960;
  localparam ang_t ANG_HALF    = 32'sd11796480;
  localparam ang_t ANG_QUARTER = 32'sd5898240;
  localparam logic signed [29:0] INV_K3 = 30'sd240441106;
  localparam logic signed [15:0] OUT_LIMIT = 16'sd23040;

  // Pipeline stage counts.
  localparam int unsigned MUL_STAGES = 4;
  localparam int unsigned PIPE_STAGES = 1 + 3 * CORDIC_STEPS + MUL_STAGES;

  typedef struct packed {
    dat_t x;
    dat_t y;
    ang_t a;
  } cvec_t;

  // Payload through the first vectoring unit, which vectors (w,z) and (x,y) side by side.
  typedef struct packed {
    cvec_t g;
    cvec_t p;
    logic  g_axis;
    logic  p_axis;
    logic  half;
  } sa_t;

  // Payload through the magnitude/beta vectoring unit.
  typedef struct packed {
    cvec_t b;
    logic  b_zero;
    ang_t  gamma;
    ang_t  phi;
  } sb_t;

  // Side data through the multiplier stages.
  typedef struct packed {
    ang_t theta;
    logic neg;
    ang_t gamma;
  } mctl_t;

  // Payload through the rotation unit.
  typedef struct packed {
    cvec_t r;
    ang_t  gamma;
  } sr_t;

  // Arctangent table, rounded to 2^-16 degree.
  function automatic ang_t qst_atan(input int unsigned i);
    ang_t v;
    case (i)
      0:       v = 32'sd2949120;
      1:       v = 32'sd1740967;
      2:       v = 32'sd919879;
      3:       v = 32'sd466945;
      4:       v = 32'sd234379;
      5:       v = 32'sd117305;
      6:       v = 32'sd58666;
      7:       v = 32'sd29335;
      8:       v = 32'sd14668;
      9:       v = 32'sd7334;
      10:      v = 32'sd3667;
      11:      v = 32'sd1833;
      12:      v = 32'sd917;
      13:      v = 32'sd458;
      14:      v = 32'sd229;
      15:      v = 32'sd115;
      16:      v = 32'sd57;
      17:      v = 32'sd29;
      18:      v = 32'sd14;
      19:      v = 32'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

  // One vectoring iteration: drives y toward zero.
  function automatic cvec_t vec_step(input cvec_t v, input int unsigned i);
    cvec_t o;
    if (v.y >= 0) begin
      o.x = v.x + (v.y >>> i);
      o.y = v.y - (v.x >>> i);
      o.a = v.a + qst_atan(i);
    end else begin
      o.x = v.x - (v.y >>> i);
      o.y = v.y + (v.x >>> i);
      o.a = v.a - qst_atan(i);
    end
    return o;
  endfunction

  // One rotation iteration: drives the residual angle toward zero.
  function automatic cvec_t rot_step(input cvec_t v, input int unsigned i);
    cvec_t o;
    if (v.a >= 0) begin
      o.x = v.x - (v.y >>> i);
      o.y = v.y + (v.x >>> i);
      o.a = v.a - qst_atan(i);
    end else begin
      o.x = v.x + (v.y >>> i);
      o.y = v.y - (v.x >>> i);
      o.a = v.a + qst_atan(i);
    end
    return o;
  endfunction

  // Saturate a wide value to the output range.
  function automatic logic signed [15:0] sat_out(input dat_t v);
    logic signed [15:0] o;
    if (v > dat_t'(OUT_LIMIT)) begin
      o = OUT_LIMIT;
    end else if (v < -dat_t'(OUT_LIMIT)) begin
      o = -OUT_LIMIT;
    end else begin
      o = v[15:0];
    end
    return o;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/quaternion_to_swing_twist.sv =====
// Throughput: one item per cycle; every stage advances together whenever
// the output register is empty or being taken.
// The depth is set by three 20-step CORDIC units and four multiplier stages.
// Reset (synchronous, active low) clears all valid bits; data is not reset.
// ----------------------------------------------------------------------------
// quaternion_to_swing_twist
// Converts a Q2.14 quaternion into swing and twist angles in Q9.7 degrees.
// ----------------------------------------------------------------------------
`default_nettype none

`include "quaternion_to_swing_twist_assert.svh"

module quaternion_to_swing_twist (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire  signed [15:0] in_quat_x,
  input  wire  signed [15:0] in_quat_y,
  input  wire  signed [15:0] in_quat_z,
  input  wire  signed [15:0] in_quat_w,
  output logic               out_valid,
  input  wire                out_ready,
  output logic signed [15:0] out_swing_x_deg,
  output logic signed [15:0] out_swing_y_deg,
  output logic signed [15:0] out_twist_deg
);

  localparam int unsigned NS = qst_pkg::CORDIC_STEPS;
  localparam int unsigned NP = qst_pkg::PIPE_STAGES;

  // Whole pipeline moves when the output register can take a new item.
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  logic [NP-1:0] vld_r, vld_nxt;
  logic          out_valid_nxt;

  assign vld_nxt       = {vld_r[NP-2:0], in_valid};
  assign out_valid_nxt = vld_r[NP-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld_r     <= vld_nxt;
      out_valid <= out_valid_nxt;
    end
  end

  // Sign fold, scaling and half-turn pre-rotation of (x,y).
  qst_pkg::sa_t s0_r, s0_nxt;
  always_comb begin
    qst_pkg::dat_t x, y, z, w;
    x = qst_pkg::dat_t'(in_quat_x);
    y = qst_pkg::dat_t'(in_quat_y);
    z = qst_pkg::dat_t'(in_quat_z);
    w = qst_pkg::dat_t'(in_quat_w);
    if (w < 0) begin
      x = -x;
      y = -y;
      z = -z;
      w = -w;
    end
    x = x <<< 10;
    y = y <<< 10;
    z = z <<< 10;
    w = w <<< 10;
    s0_nxt.half = 1'b0;
    if (x < 0) begin
      x = -x;
      y = -y;
      s0_nxt.half = 1'b1;
    end
    s0_nxt.g      = '{x: w, y: z, a: '0};
    s0_nxt.p      = '{x: x, y: y, a: '0};
    s0_nxt.g_axis = (z == 0);
    s0_nxt.p_axis = (y == 0);
  end

  // Vectoring of (w,z) and (x,y) side by side.
  qst_pkg::sa_t a_r [NS];
  qst_pkg::sa_t a_nxt [NS];
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      qst_pkg::sa_t src;
      src = (k == 0) ? s0_r : a_r[k-1];
      a_nxt[k]   = src;
      a_nxt[k].g = qst_pkg::vec_step(src.g, k);
      a_nxt[k].p = qst_pkg::vec_step(src.p, k);
    end
  end

  // Angles and start vector of the beta vectoring.
  qst_pkg::sb_t b_src;
  always_comb begin
    qst_pkg::ang_t pa;
    pa = a_r[NS-1].p_axis ? '0 : a_r[NS-1].p.a;
    b_src.gamma  = a_r[NS-1].g_axis ? '0 : a_r[NS-1].g.a;
    b_src.phi    = (a_r[NS-1].half ? qst_pkg::ANG_HALF : '0) + pa;
    b_src.b      = '{x: a_r[NS-1].g.x, y: a_r[NS-1].p.x, a: '0};
    b_src.b_zero = (a_r[NS-1].p.x == 0);
  end

  qst_pkg::sb_t b_r [NS];
  qst_pkg::sb_t b_nxt [NS];
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      qst_pkg::sb_t src;
      src = (k == 0) ? b_src : b_r[k-1];
      b_nxt[k]   = src;
      b_nxt[k].b = qst_pkg::vec_step(src.b, k);
    end
  end

  // Multiplier stage 1: beta times |q|, and direction reduction.
  logic signed [53:0] m1_prod_r, m1_prod_nxt;
  qst_pkg::mctl_t     m1_ctl_r, m1_ctl_nxt;
  always_comb begin
    logic signed [23:0] beta;
    logic signed [29:0] qmag;
    qst_pkg::ang_t      th;
    beta = b_r[NS-1].b_zero ? '0 : b_r[NS-1].b.a[23:0];
    qmag = b_r[NS-1].b.x[29:0];
    m1_prod_nxt = 54'(beta) * 54'(qmag);
    th = b_r[NS-1].phi + b_r[NS-1].gamma;
    if (th >= qst_pkg::ANG_HALF) begin
      th = th - qst_pkg::ANG_FULL;
    end
    if (th < -qst_pkg::ANG_HALF) begin
      th = th + qst_pkg::ANG_FULL;
    end
    m1_ctl_nxt.neg = 1'b0;
    if (th > qst_pkg::ANG_QUARTER) begin
      th = th - qst_pkg::ANG_HALF;
      m1_ctl_nxt.neg = 1'b1;
    end else if (th < -qst_pkg::ANG_QUARTER) begin
      th = th + qst_pkg::ANG_HALF;
      m1_ctl_nxt.neg = 1'b1;
    end
    m1_ctl_nxt.theta = th;
    m1_ctl_nxt.gamma = b_r[NS-1].gamma;
  end

  // Multiplier stage 2: round the product down to t.
  logic signed [31:0] m2_t_r, m2_t_nxt;
  qst_pkg::mctl_t     m2_ctl_r;
  always_comb begin
    logic signed [53:0] s;
    s = (m1_prod_r + (54'sd1 <<< 19)) >>> 20;
    m2_t_nxt = s[31:0];
  end

  // Multiplier stage 3: t times the inverse cubed CORDIC gain.
  logic signed [61:0] m3_prod_r, m3_prod_nxt;
  qst_pkg::mctl_t     m3_ctl_r;
  assign m3_prod_nxt = 62'(m2_t_r) * 62'(qst_pkg::INV_K3);

  // Multiplier stage 4: round to the swing length and start the rotation.
  qst_pkg::sr_t m4_r, m4_nxt;
  always_comb begin
    logic signed [61:0] s;
    qst_pkg::dat_t      len;
    s   = (m3_prod_r + (62'sd1 <<< 33)) >>> 34;
    len = s[qst_pkg::DW-1:0];
    if (m3_ctl_r.neg) begin
      len = -len;
    end
    m4_nxt.r     = '{x: len, y: '0, a: m3_ctl_r.theta};
    m4_nxt.gamma = m3_ctl_r.gamma;
  end

  // Rotation of the swing vector by its direction angle.
  qst_pkg::sr_t r_r [NS];
  qst_pkg::sr_t r_nxt [NS];
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      qst_pkg::sr_t src;
      src = (k == 0) ? m4_r : r_r[k-1];
      r_nxt[k]   = src;
      r_nxt[k].r = qst_pkg::rot_step(src.r, k);
    end
  end

  // Output rounding and saturation.
  logic signed [15:0] sx_nxt, sy_nxt, tw_nxt;
  always_comb begin
    qst_pkg::dat_t tw;
    sx_nxt = qst_pkg::sat_out((r_r[NS-1].r.x + 40'sd128) >>> 8);
    sy_nxt = qst_pkg::sat_out((r_r[NS-1].r.y + 40'sd128) >>> 8);
    tw     = qst_pkg::dat_t'(r_r[NS-1].gamma);
    tw_nxt = qst_pkg::sat_out(((tw <<< 1) + 40'sd256) >>> 9);
  end

  // Datapath registers, no reset.
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_r      <= s0_nxt;
      a_r       <= a_nxt;
      b_r       <= b_nxt;
      m1_prod_r <= m1_prod_nxt;
      m1_ctl_r  <= m1_ctl_nxt;
      m2_t_r    <= m2_t_nxt;
      m2_ctl_r  <= m1_ctl_r;
      m3_prod_r <= m3_prod_nxt;
      m3_ctl_r  <= m2_ctl_r;
      m4_r      <= m4_nxt;
      r_r       <= r_nxt;
      out_swing_x_deg <= sx_nxt;
      out_swing_y_deg <= sy_nxt;
      out_twist_deg   <= tw_nxt;
    end
  end

  // A stalled output freezes every stage's valid bit.
  `QST_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, $stable(vld_r), "pipeline moved during stall")
  // An item leaving the last stage reaches the output register.
  `QST_ASSERT_NEXT(a_drain, clk, rst_n, adv && vld_r[NP-1], out_valid, "item lost at output")
  // The twist result stays within the saturation limits.
  `QST_ASSERT_NOW(a_twist_rng, clk, rst_n, out_valid, (out_twist_deg <= qst_pkg::OUT_LIMIT) && (out_twist_deg >= -qst_pkg::OUT_LIMIT), "twist out of range")

endmodule

`default_nettype wire
